// ----- hdl/slli_pkg.sv -----
// slli_pkg: shared types and constants for the sorted linked list insert block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package slli_pkg;

   // default sizing, handed to the top level parameters
   localparam int CAPACITY_DEF     = 64;
   localparam int KEY_BITS_DEF     = 32;
   localparam int PAYLOAD_BITS_DEF = 32;

   // fixed port field widths
   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 32;
   localparam int SLOT_W    = 6;

   // request function codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LIST   = 1'b1;

   // response status codes
   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_ENTRY    = 2'd2,
      STATUS_EMPTY    = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_WALK,
      ST_INS_NODE,
      ST_INS_LINK,
      ST_EMIT,
      ST_LST_WALK
   } state_type;

endpackage

`default_nettype wire

// ----- hdl/slli_key_cmp.sv -----
// slli_key_cmp: signed key compare unit shared by every step of the insert walk
// depends on slli_pkg
`timescale 1ns / 1ps
`default_nettype none

module slli_key_cmp import slli_pkg::*; #(
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input  wire logic signed [KEY_BITS-1:0] new_key,
   input  wire logic signed [KEY_BITS-1:0] node_key,
   output logic                            new_less
);

   // strictly less, so equal keys walk past and keep arrival order
   assign new_less = (new_key < node_key);

endmodule

`default_nettype wire

// ----- hdl/sorted_linked_list_insert.sv -----
// sorted_linked_list_insert: top level, node store, walk sequencer, response register
// depends on slli_pkg and slli_key_cmp
//
//  channel | dir | beat accepted when    | payload
//  --------+-----+-----------------------+--------------------------------------------
//  req     | in  | req_valid & !req_stall| req_func, req_key, req_payload
//  rsp     | out | rsp_valid & !rsp_stall| rsp_status, rsp_key_res, rsp_payload_res,
//          |     |                       | rsp_slot, rsp_last
//
// insert: accept, then a walk that visits one node at a time (at most CAPACITY), paced by the
//   single read port of the node store and the one key compare unit, then the write of the
//   new node, then of the predecessor link if there is one, and the load of the response
// list: accept, then one response beat per cycle while not stalled, one store read per entry
// full store or empty list: accept, then one response beat
// reset clears the sequencer, list head, slot counter and response valid; the node store
//   is not cleared, only linked nodes are ever read
// rsp_stall holds the sequencer at its current beat; req_stall is high while an item is
//   in work, and a new item is taken while the last response still waits
`timescale 1ns / 1ps
`default_nettype none

module sorted_linked_list_insert import slli_pkg::*; #(
   parameter int CAPACITY     = CAPACITY_DEF,
   parameter int KEY_BITS     = KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_func,
   input  wire logic signed [KEY_W-1:0] req_key,
   input  wire logic [PAYLOAD_W-1:0]  req_payload,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic signed [KEY_W-1:0]    rsp_key_res,
   output logic [PAYLOAD_W-1:0]       rsp_payload_res,
   output logic [SLOT_W-1:0]          rsp_slot,
   output logic                       rsp_last
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int PTR_W = $clog2(CAPACITY + 1);
   // pointer value for "no node"
   localparam logic [PTR_W-1:0] NO_NODE = PTR_W'(CAPACITY);
   localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);

   // node store
   logic signed [KEY_BITS-1:0] key_mem  [CAPACITY];
   logic [PAYLOAD_BITS-1:0]    pay_mem  [CAPACITY];
   logic [PTR_W-1:0]           next_mem [CAPACITY];

   // registered store read data
   logic signed [KEY_BITS-1:0] key_rd_ff;
   logic [PAYLOAD_BITS-1:0]    pay_rd_ff;
   logic [PTR_W-1:0]           next_rd_ff;

   // sequencer state
   state_type                  state_ff, state_in;
   logic [PTR_W-1:0]           cur_ff, cur_in;
   logic [PTR_W-1:0]           prev_ff, prev_in;
   logic [PTR_W-1:0]           cnt_ff, cnt_in;
   logic [IDX_W-1:0]           slot_ff, slot_in;
   logic signed [KEY_BITS-1:0] key_ff, key_in;
   logic [PAYLOAD_BITS-1:0]    pay_ff, pay_in;
   logic [PTR_W-1:0]           head_ff, head_in;
   logic [PTR_W-1:0]           used_ff, used_in;
   status_type                 res_status_ff, res_status_in;

   // response register
   logic                       rsp_valid_ff;
   logic [1:0]                 rsp_status_ff;
   logic signed [KEY_W-1:0]    rsp_key_ff;
   logic [PAYLOAD_W-1:0]       rsp_payload_ff;
   logic [SLOT_W-1:0]          rsp_slot_ff;
   logic                       rsp_last_ff;

   // combinational controls
   logic                       rsp_load;
   status_type                 ld_status;
   logic signed [KEY_W-1:0]    ld_key;
   logic [PAYLOAD_W-1:0]       ld_payload;
   logic [SLOT_W-1:0]          ld_slot;
   logic                       ld_last;
   logic                       wr_node;
   logic                       wr_next;
   logic [IDX_W-1:0]           next_wr_idx;
   logic [PTR_W-1:0]           next_wr_data;
   logic [IDX_W-1:0]           rd_idx;
   logic                       out_free;
   logic                       new_less;
   logic [PTR_W-1:0]           cnt_nx;
   logic                       walk_end;

   // shared compare unit: new key against the node under the walk pointer
   slli_key_cmp #(
      .KEY_BITS (KEY_BITS)
   ) u_cmp (
      .new_key  (key_ff),
      .node_key (key_rd_ff),
      .new_less (new_less)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign cnt_nx    = cnt_ff + PTR_ONE;
   // the walk stops at the list tail or after CAPACITY nodes
   assign walk_end  = (next_rd_ff >= NO_NODE) || (cnt_nx >= NO_NODE);

   // read address follows the pointer the sequencer moves to, so data is ready next cycle
   assign rd_idx = (cur_in < NO_NODE) ? cur_in[IDX_W-1:0] : '0;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      cnt_in        = cnt_ff;
      slot_in       = slot_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      head_in       = head_ff;
      used_in       = used_ff;
      res_status_in = res_status_ff;
      rsp_load      = 1'b0;
      ld_status     = STATUS_ENTRY;
      ld_key        = KEY_W'(key_rd_ff);
      ld_payload    = PAYLOAD_W'(pay_rd_ff);
      ld_slot       = SLOT_W'(cur_ff);
      ld_last       = walk_end;
      wr_node       = 1'b0;
      wr_next       = 1'b0;
      next_wr_idx   = slot_ff;
      next_wr_data  = cur_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_INSERT) begin
                  // key wraps or sign extends, payload truncates or zero extends
                  key_in = KEY_BITS'(req_key);
                  pay_in = PAYLOAD_BITS'(req_payload);
                  if (used_ff >= NO_NODE) begin
                     res_status_in = STATUS_FULL;
                     state_in      = ST_EMIT;
                  end else begin
                     res_status_in = STATUS_INSERTED;
                     slot_in       = used_ff[IDX_W-1:0];
                     used_in       = used_ff + PTR_ONE;
                     prev_in       = NO_NODE;
                     cur_in        = head_ff;
                     cnt_in        = '0;
                     state_in      = (head_ff >= NO_NODE) ? ST_INS_NODE : ST_INS_WALK;
                  end
               end else begin
                  if (head_ff >= NO_NODE) begin
                     res_status_in = STATUS_EMPTY;
                     state_in      = ST_EMIT;
                  end else begin
                     cur_in   = head_ff;
                     cnt_in   = '0;
                     state_in = ST_LST_WALK;
                  end
               end
            end
         end

         ST_INS_WALK: begin
            if (new_less) begin
               state_in = ST_INS_NODE;
            end else begin
               prev_in = cur_ff;
               cur_in  = next_rd_ff;
               cnt_in  = cnt_nx;
               if (walk_end) begin
                  state_in = ST_INS_NODE;
               end
            end
         end

         ST_INS_NODE: begin
            // new node points at the first greater node, or the tail marker
            wr_node      = 1'b1;
            wr_next      = 1'b1;
            next_wr_idx  = slot_ff;
            next_wr_data = cur_ff;
            if (prev_ff >= NO_NODE) begin
               head_in  = PTR_W'(slot_ff);
               state_in = ST_EMIT;
            end else begin
               state_in = ST_INS_LINK;
            end
         end

         ST_INS_LINK: begin
            wr_next      = 1'b1;
            next_wr_idx  = prev_ff[IDX_W-1:0];
            next_wr_data = PTR_W'(slot_ff);
            state_in     = ST_EMIT;
         end

         ST_EMIT: begin
            ld_status = res_status_ff;
            ld_last   = 1'b1;
            if (res_status_ff == STATUS_INSERTED) begin
               ld_key     = KEY_W'(key_ff);
               ld_payload = PAYLOAD_W'(pay_ff);
               ld_slot    = SLOT_W'(slot_ff);
            end else begin
               ld_key     = '0;
               ld_payload = '0;
               ld_slot    = '0;
            end
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         ST_LST_WALK: begin
            // one entry per beat; a stall keeps the pointer, so the read repeats
            if (out_free) begin
               rsp_load = 1'b1;
               cur_in   = next_rd_ff;
               cnt_in   = cnt_nx;
               if (walk_end) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= NO_NODE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         used_ff  <= used_in;
      end
   end

   // walk registers, no reset needed
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      cnt_ff        <= cnt_in;
      slot_ff       <= slot_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      res_status_ff <= res_status_in;
   end

   // node store: one write port per array, one registered read port
   always_ff @(posedge clock) begin
      if (wr_node) begin
         key_mem[slot_ff] <= key_ff;
         pay_mem[slot_ff] <= pay_ff;
      end
      if (wr_next) begin
         next_mem[next_wr_idx] <= next_wr_data;
      end
      key_rd_ff  <= key_mem[rd_idx];
      pay_rd_ff  <= pay_mem[rd_idx];
      next_rd_ff <= next_mem[rd_idx];
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff  <= ld_status;
         rsp_key_ff     <= ld_key;
         rsp_payload_ff <= ld_payload;
         rsp_slot_ff    <= ld_slot;
         rsp_last_ff    <= ld_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_key_res     = rsp_key_ff;
   assign rsp_payload_res = rsp_payload_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

// ----- hdl/slli_checker.sv -----
// slli_port_props: port level checks of the sorted linked list insert block, with its bind
// depends on slli_pkg; attaches to sorted_linked_list_insert
`timescale 1ns / 1ps
`default_nettype none

module slli_port_props import slli_pkg::*; (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_stall,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_stall,
   input wire logic [1:0]              rsp_status,
   input wire logic signed [KEY_W-1:0] rsp_key_res,
   input wire logic [PAYLOAD_W-1:0]    rsp_payload_res,
   input wire logic [SLOT_W-1:0]       rsp_slot,
   input wire logic                    rsp_last
);

   // a response beat waits until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // every accepted item takes the sequencer out of idle, so the request side stalls after a beat
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken on back to back cycles");

   // single-beat statuses always close their item
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_INSERTED || rsp_status == STATUS_FULL ||
                    rsp_status == STATUS_EMPTY) |-> rsp_last)
      else $error("insert, full or empty beat without last");

   // full and empty beats carry no record
   a_blank_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL || rsp_status == STATUS_EMPTY) |->
      (rsp_key_res == '0) && (rsp_payload_res == '0) && (rsp_slot == '0))
      else $error("full or empty beat with record fields set");

endmodule

bind sorted_linked_list_insert slli_port_props u_slli_port_props (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_key_res     (rsp_key_res),
   .rsp_payload_res (rsp_payload_res),
   .rsp_slot        (rsp_slot),
   .rsp_last        (rsp_last)
);

`default_nettype wire
